>>> rtl/rgb_to_hsv_pixel_macros.svh
// Assertion macros shared by the RGB to HSV pixel converter.
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RHSV_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RHSV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rhsv_pkg.sv
// Types and constants shared by the RGB to HSV pixel converter.
`timescale 1ns / 1ps
`default_nettype none

package rhsv_pkg;

  localparam int unsigned ChanW         = 8;
  localparam int unsigned HueDivW       = 11;
  localparam int unsigned SatDivW       = ChanW;
  localparam int unsigned QuoW          = 16;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned NumDivStages  = QuoW / StepsPerStage;

  typedef struct packed {
    logic [HueDivW-1:0] hue_rem;
    logic [HueDivW-1:0] hue_div;
    logic [QuoW-1:0]    hue_quo;
    logic [SatDivW-1:0] sat_rem;
    logic [SatDivW-1:0] sat_div;
    logic [QuoW-1:0]    sat_num;
    logic [QuoW-1:0]    sat_quo;
    logic [ChanW-1:0]   bright;
  } div_data_t;

endpackage

`default_nettype wire

>>> rtl/rhsv_div_stage.sv
// One pipeline stage of the hue and saturation restoring dividers.
`timescale 1ns / 1ps
`default_nettype none

module rhsv_div_stage
  import rhsv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire div_data_t data_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output div_data_t      data_o
);

  div_data_t          data_d;
  div_data_t          data_q;
  logic               valid_q;
  logic [HueDivW:0]   hue_shift;
  logic [SatDivW:0]   sat_shift;

  always_comb begin
    data_d    = data_i;
    hue_shift = '0;
    sat_shift = '0;
    for (int unsigned s = 0; s < StepsPerStage; s++) begin
      hue_shift = {data_d.hue_rem, 1'b0};
      if (hue_shift >= {1'b0, data_d.hue_div}) begin
        data_d.hue_rem = HueDivW'(hue_shift - {1'b0, data_d.hue_div});
        data_d.hue_quo = {data_d.hue_quo[QuoW-2:0], 1'b1};
      end else begin
        data_d.hue_rem = hue_shift[HueDivW-1:0];
        data_d.hue_quo = {data_d.hue_quo[QuoW-2:0], 1'b0};
      end
      sat_shift = {data_d.sat_rem, data_d.sat_num[QuoW-1]};
      data_d.sat_num = {data_d.sat_num[QuoW-2:0], 1'b0};
      if (sat_shift >= {1'b0, data_d.sat_div}) begin
        data_d.sat_rem = SatDivW'(sat_shift - {1'b0, data_d.sat_div});
        data_d.sat_quo = {data_d.sat_quo[QuoW-2:0], 1'b1};
      end else begin
        data_d.sat_rem = sat_shift[SatDivW-1:0];
        data_d.sat_quo = {data_d.sat_quo[QuoW-2:0], 1'b0};
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> rtl/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel converter.
//
// The input channel takes one packed color word per beat on rgb_word_i, with
// red in bits 7:0, green in 15:8 and blue in 23:16; the top byte is ignored.
// The output channel gives hue, saturation and brightness for each pixel, in
// the order the pixels came in, one result beat per input beat.
// Both channels use a valid and ready handshake.
// The datapath is a five-register pipeline: a front stage finds the maximum,
// minimum, spread and hue sector, and four divider stages each resolve four
// quotient bits of the hue and saturation divisions.
// A taken beat passes through the front register and then the divider stage registers before its result is offered.
// The block takes one pixel per cycle when the receiver keeps ready high.
// When the receiver stalls, each stage holds its beat and empty stages keep
// filling, so input ready falls only once all five registers hold data.
// Reset clears every valid bit, so the pipeline starts empty.
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsv_pixel_macros.svh"

module rgb_to_hsv_pixel
  import rhsv_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [31:0]  rgb_word_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [15:0]       hue_o,
  output logic [15:0]       saturation_o,
  output logic [7:0]        brightness_o
);

  logic [ChanW-1:0]       red;
  logic [ChanW-1:0]       green;
  logic [ChanW-1:0]       blue;
  logic [ChanW-1:0]       hi;
  logic [ChanW-1:0]       lo;
  logic [ChanW-1:0]       spread;
  logic [HueDivW-1:0]     spread_w;
  logic [HueDivW-1:0]     six_d;
  logic [HueDivW-1:0]     hue_num;
  logic [ChanW+QuoW-1:0]  sat_full;
  logic                   grey;
  div_data_t              front_d;
  div_data_t              front_data_q;
  logic                   front_valid_q;

  div_data_t              data  [NumDivStages+1];
  logic [NumDivStages:0]  vld;
  logic [NumDivStages+1:0] acc;

  always_comb begin
    red      = rgb_word_i[7:0];
    green    = rgb_word_i[15:8];
    blue     = rgb_word_i[23:16];
    hi       = (red >= green) ? red : green;
    hi       = (hi >= blue) ? hi : blue;
    lo       = (red <= green) ? red : green;
    lo       = (lo <= blue) ? lo : blue;
    spread   = hi - lo;
    grey     = (spread == '0);
    spread_w = HueDivW'(spread);
    six_d    = (spread_w << 2) + (spread_w << 1);

    if ((red >= green) && (red >= blue)) begin
      if (green >= blue) begin
        hue_num = HueDivW'(green - blue);
      end else begin
        hue_num = six_d - HueDivW'(blue - green);
      end
    end else if (green >= blue) begin
      hue_num = (spread_w << 1) + HueDivW'(blue) - HueDivW'(red);
    end else begin
      hue_num = (spread_w << 2) + HueDivW'(red) - HueDivW'(green);
    end

    sat_full = {spread, {QuoW{1'b0}}} - (ChanW+QuoW)'(spread);

    front_d.hue_rem = grey ? '0 : hue_num;
    front_d.hue_div = grey ? HueDivW'(1) : six_d;
    front_d.hue_quo = '0;
    front_d.sat_rem = sat_full[ChanW+QuoW-1:QuoW];
    front_d.sat_div = grey ? SatDivW'(1) : hi;
    front_d.sat_num = sat_full[QuoW-1:0];
    front_d.sat_quo = '0;
    front_d.bright  = hi;
  end

  assign acc[0]               = !front_valid_q || acc[1];
  assign acc[NumDivStages+1]  = out_ready_i;
  assign in_ready_o           = acc[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (acc[0]) begin
      front_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc[0] && in_valid_i) begin
      front_data_q <= front_d;
    end
  end

  assign vld[0]  = front_valid_q;
  assign data[0] = front_data_q;

  for (genvar k = 0; k < NumDivStages; k++) begin : g_div
    rhsv_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (acc[k+1]),
      .data_i  (data[k]),
      .valid_o (vld[k+1]),
      .ready_i (acc[k+2]),
      .data_o  (data[k+1])
    );
  end

  assign out_valid_o  = vld[NumDivStages];
  assign hue_o        = data[NumDivStages].hue_quo;
  assign saturation_o = data[NumDivStages].sat_quo;
  assign brightness_o = data[NumDivStages].bright;

  `RHSV_ASSERT(a_full_when_blocked, !in_ready_o, &vld, "input blocked with a free stage")
  `RHSV_ASSERT_NXT(a_front_loaded, in_valid_i && in_ready_o, front_valid_q,
                   "taken beat not in front stage")
  `RHSV_ASSERT(a_grey_hue_zero, out_valid_o && (saturation_o == 16'd0), hue_o == 16'd0,
               "grey pixel with nonzero hue")

endmodule

`default_nettype wire
